// ===== sv/ur2s_pkg.sv =====
// shared types and constants of the two-sensor ultrasonic ranger
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package ur2s_pkg;

  localparam int TIMER_W     = 32;
  localparam int NUM_SENSORS = 2;
  localparam int NUM_CH      = 2;
  localparam int TICK_W      = 8;
  localparam int ECHO_W      = 20;
  localparam int DIST_W      = 28;
  localparam int CFG_W       = 20;
  localparam int CMP_W       = (TIMER_W > ECHO_W) ? TIMER_W : ECHO_W;
  localparam int PROD_W      = ECHO_W + 9;

  localparam logic [8:0]        SOUND_MUL     = 9'd343;
  localparam logic [TICK_W-1:0] RST_TRIG_LOW  = 8'd2;
  localparam logic [TICK_W-1:0] RST_TRIG_HIGH = 8'd10;
  localparam logic [ECHO_W-1:0] RST_MIN_ECHO  = 20'd100;
  localparam logic [ECHO_W-1:0] RST_MAX_ECHO  = 20'd18000;

  typedef enum logic [1:0] {
    REQ_START   = 2'd0,
    REQ_TICK    = 2'd1,
    REQ_CAPTURE = 2'd2,
    REQ_READ    = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    CFG_TRIG_LOW  = 2'd0,
    CFG_TRIG_HIGH = 2'd1,
    CFG_MIN_ECHO  = 2'd2,
    CFG_MAX_ECHO  = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_LOW   = 2'd1,
    PH_HIGH  = 2'd2,
    PH_SPARE = 2'd3
  } trig_phase_t;

  typedef struct packed {
    logic level;
    logic active;
  } trig_stat_t;

  // first member sits in the high bits
  typedef struct packed {
    logic [3:0]        pad;
    logic              pair_y_invalid;
    logic [DIST_W-1:0] pair_y_um;
    logic              pair_x_invalid;
    logic [DIST_W-1:0] pair_x_um;
    logic              pair_updated;
    logic              measure_out_of_range;
    logic [DIST_W-1:0] measure_dist_um;
    logic              measure_sensor;
    logic              measure_done;
    logic              trigger_active;
    logic              trigger_level;
  } res_t;

  localparam int OUT_W = $bits(res_t);

endpackage

// ===== sv/ur2s_trig.sv =====
// trigger sequencer: low wait, high pulse, stop
// depends on ur2s_pkg
`timescale 1ns / 1ps

module ur2s_trig import ur2s_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              tick,
  input  logic [TICK_W-1:0] low_ticks,
  input  logic [TICK_W-1:0] high_ticks,
  output trig_stat_t        stat_nxt
);

  trig_phase_t       phase_r, phase_nxt;
  logic [TICK_W-1:0] count_r, count_nxt;
  logic              running_r, running_nxt;
  logic              out_r, out_nxt;
  logic [TICK_W-1:0] count_inc;
  logic              step;

  assign count_inc = count_r + {{(TICK_W-1){1'b0}}, 1'b1};
  assign step      = tick && running_r;

  always_comb begin
    phase_nxt = phase_r;
    if (step) begin
      case (phase_r)
        PH_IDLE: phase_nxt = PH_LOW;
        PH_LOW:  if (count_inc == low_ticks) phase_nxt = PH_HIGH;
        PH_HIGH: if (count_inc == high_ticks) phase_nxt = PH_IDLE;
        default: phase_nxt = PH_IDLE;
      endcase
    end
  end

  always_comb begin
    count_nxt   = count_r;
    out_nxt     = out_r;
    running_nxt = running_r || start;
    if (step) begin
      case (phase_r)
        PH_IDLE: out_nxt = 1'b0;
        PH_LOW: begin
          count_nxt = count_inc;
          if (count_inc == low_ticks) begin
            count_nxt = '0;
            out_nxt   = 1'b1;
          end
        end
        PH_HIGH: begin
          count_nxt = count_inc;
          if (count_inc == high_ticks) begin
            count_nxt   = '0;
            out_nxt     = 1'b0;
            running_nxt = 1'b0;
          end
        end
        default: out_nxt = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      count_r   <= '0;
      running_r <= 1'b0;
      out_r     <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      count_r   <= count_nxt;
      running_r <= running_nxt;
      out_r     <= out_nxt;
    end
  end

  assign stat_nxt.level  = out_nxt;
  assign stat_nxt.active = running_nxt;

endmodule

// ===== sv/ur2s_dist.sv =====
// echo duration to distance: modular difference, range check, times 343 over 2
// depends on ur2s_pkg
`timescale 1ns / 1ps

module ur2s_dist import ur2s_pkg::*; (
  input  logic [TIMER_W-1:0] cap,
  input  logic [TIMER_W-1:0] first,
  input  logic [ECHO_W-1:0]  min_ticks,
  input  logic [ECHO_W-1:0]  max_ticks,
  output logic [DIST_W-1:0]  dist_um,
  output logic               bad
);

  logic [TIMER_W-1:0] diff;
  logic [CMP_W-1:0]   diff_ext;
  logic [CMP_W-1:0]   min_ext;
  logic [CMP_W-1:0]   max_ext;
  logic [PROD_W-1:0]  prod;

  assign diff     = cap - first;
  assign diff_ext = CMP_W'(diff);
  assign min_ext  = CMP_W'(min_ticks);
  assign max_ext  = CMP_W'(max_ticks);
  assign bad      = (diff_ext < min_ext) || (diff_ext > max_ext);

  // in range the duration fits the echo width
  assign prod    = PROD_W'(diff_ext[ECHO_W-1:0]) * PROD_W'(SOUND_MUL);
  assign dist_um = bad ? '0 : DIST_W'(prod[PROD_W-1:1]);

endmodule

// ===== sv/ultrasonic_ranger_two_sensor.sv =====
// Two-sensor ultrasonic ranger controller.
// in_* beats carry requests: start (arms both echo channels and the trigger
// sequencer), microsecond tick, echo capture of a timer value, read pair.
// out_* beats carry one result per request: trigger level and activity, the
// distance completed by a capture, and the latched pair of distances.
// cfg_* writes the trigger timing and echo range limits; the user must write
// only while idle; the block does not enforce it. A request passes the input
// register, then the result register; one request per cycle is sustained while
// out_tready stays high, bounded by the 20x9 distance multiply and compares.
// Reset clears the sequencer, the echo channels and the pair latch and loads
// the default register values; no result is pending after reset.
// When the receiver stalls, the result register holds; the input register
// still takes a beat while it is empty, then in_tready drops until
// out_tready frees the result register.
// Depends on ur2s_pkg, ur2s_trig and ur2s_dist.
`timescale 1ns / 1ps

module ultrasonic_ranger_two_sensor import ur2s_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [31:0]       in_tdata,   // capture_value
  input  logic [2:0]        in_tuser,   // req_type, sensor_sel
  output logic              out_tvalid,
  input  logic              out_tready,
  // trigger_level, trigger_active, measure_done, measure_sensor,
  // measure_dist_um, measure_out_of_range, pair_updated, pair_x_um,
  // pair_x_invalid, pair_y_um, pair_y_invalid, zero fill
  output logic [OUT_W-1:0]  out_tdata,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [CFG_W-1:0]  cfg_wdata
);

  // configuration
  logic [TICK_W-1:0] trig_low_r, trig_high_r;
  logic [ECHO_W-1:0] min_echo_r, max_echo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trig_low_r  <= RST_TRIG_LOW;
      trig_high_r <= RST_TRIG_HIGH;
      min_echo_r  <= RST_MIN_ECHO;
      max_echo_r  <= RST_MAX_ECHO;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_TRIG_LOW:  trig_low_r  <= cfg_wdata[TICK_W-1:0];
        CFG_TRIG_HIGH: trig_high_r <= cfg_wdata[TICK_W-1:0];
        CFG_MIN_ECHO:  min_echo_r  <= cfg_wdata[ECHO_W-1:0];
        CFG_MAX_ECHO:  max_echo_r  <= cfg_wdata[ECHO_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  logic               in_valid_r;
  req_t               req_r;
  logic               sel_r;
  logic [TIMER_W-1:0] cap_r;
  logic               out_valid_r;
  res_t               res_r, res_nxt;
  logic               advance, fire;

  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !in_valid_r || advance;
  assign fire      = in_valid_r && advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      req_r <= req_t'(in_tuser[1:0]);
      sel_r <= in_tuser[2];
      cap_r <= in_tdata[TIMER_W-1:0];
    end
  end

  // per-sensor state
  logic                          armed_r[NUM_CH], armed_nxt[NUM_CH];
  logic                          rise_r[NUM_CH], rise_nxt[NUM_CH];
  logic [TIMER_W-1:0]            first_r[NUM_CH], first_nxt[NUM_CH];
  logic                          ready_r[NUM_CH], ready_nxt[NUM_CH];
  logic [DIST_W-1:0]             sdist_r[NUM_CH], sdist_nxt[NUM_CH];
  logic                          sbad_r[NUM_CH], sbad_nxt[NUM_CH];
  logic [DIST_W-1:0]             pdist_r[NUM_CH], pdist_nxt[NUM_CH];
  logic                          pbad_r[NUM_CH], pbad_nxt[NUM_CH];

  trig_stat_t         trig_stat;
  logic [DIST_W-1:0]  meas_dist;
  logic               meas_bad;
  logic               sel_ok, done, all_ready, updated;

  ur2s_trig u_trig (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (fire && (req_r == REQ_START)),
    .tick       (fire && (req_r == REQ_TICK)),
    .low_ticks  (trig_low_r),
    .high_ticks (trig_high_r),
    .stat_nxt   (trig_stat)
  );

  ur2s_dist u_dist (
    .cap       (cap_r),
    .first     (first_r[sel_r]),
    .min_ticks (min_echo_r),
    .max_ticks (max_echo_r),
    .dist_um   (meas_dist),
    .bad       (meas_bad)
  );

  assign sel_ok = (32'(sel_r) < NUM_SENSORS) && armed_r[sel_r];
  assign done   = (req_r == REQ_CAPTURE) && sel_ok && rise_r[sel_r];

  always_comb begin
    all_ready = 1'b1;
    for (int i = 0; i < NUM_CH; i++) begin
      if (i < NUM_SENSORS && !ready_r[i]) all_ready = 1'b0;
    end
  end

  assign updated = (req_r == REQ_READ) && all_ready;

  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      armed_nxt[i] = armed_r[i];
      rise_nxt[i]  = rise_r[i];
      first_nxt[i] = first_r[i];
      ready_nxt[i] = ready_r[i];
      sdist_nxt[i] = sdist_r[i];
      sbad_nxt[i]  = sbad_r[i];
      pdist_nxt[i] = pdist_r[i];
      pbad_nxt[i]  = pbad_r[i];
      if (i < NUM_SENSORS) begin
        case (req_r)
          REQ_START: armed_nxt[i] = 1'b1;
          REQ_CAPTURE: begin
            if (sel_ok && (32'(sel_r) == i)) begin
              if (!rise_r[i]) begin
                first_nxt[i] = cap_r;
                rise_nxt[i]  = 1'b1;
              end else begin
                sdist_nxt[i] = meas_dist;
                sbad_nxt[i]  = meas_bad;
                ready_nxt[i] = 1'b1;
                rise_nxt[i]  = 1'b0;
                armed_nxt[i] = 1'b0;
              end
            end
          end
          REQ_READ: begin
            if (all_ready) begin
              ready_nxt[i] = 1'b0;
              pdist_nxt[i] = sdist_r[i];
              pbad_nxt[i]  = sbad_r[i];
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CH; i++) begin
        armed_r[i] <= 1'b0;
        rise_r[i]  <= 1'b0;
        first_r[i] <= '0;
        ready_r[i] <= 1'b0;
        sdist_r[i] <= '0;
        sbad_r[i]  <= 1'b0;
        pdist_r[i] <= '0;
        pbad_r[i]  <= 1'b0;
      end
    end else if (fire) begin
      for (int i = 0; i < NUM_CH; i++) begin
        armed_r[i] <= armed_nxt[i];
        rise_r[i]  <= rise_nxt[i];
        first_r[i] <= first_nxt[i];
        ready_r[i] <= ready_nxt[i];
        sdist_r[i] <= sdist_nxt[i];
        sbad_r[i]  <= sbad_nxt[i];
        pdist_r[i] <= pdist_nxt[i];
        pbad_r[i]  <= pbad_nxt[i];
      end
    end
  end

  // result assembly
  always_comb begin
    res_nxt                      = '0;
    res_nxt.trigger_level        = trig_stat.level;
    res_nxt.trigger_active       = trig_stat.active;
    res_nxt.measure_done         = done;
    res_nxt.measure_sensor       = done && sel_r;
    res_nxt.measure_dist_um      = done ? meas_dist : '0;
    res_nxt.measure_out_of_range = done && meas_bad;
    res_nxt.pair_updated         = updated;
    res_nxt.pair_x_um            = pdist_nxt[0];
    res_nxt.pair_x_invalid       = pbad_nxt[0];
    res_nxt.pair_y_um            = pdist_nxt[1];
    res_nxt.pair_y_invalid       = pbad_nxt[1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = res_r;

`ifndef SYNTH
  a_trig_high_running: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.trigger_level) |-> res_r.trigger_active)
    else $error("trigger high while sequencer stopped");

  a_no_meas_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !res_r.measure_done) |->
      (res_r.measure_dist_um == '0 && !res_r.measure_out_of_range && !res_r.measure_sensor))
    else $error("measurement fields set without a completed measurement");

  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.measure_out_of_range) |-> (res_r.measure_dist_um == '0))
    else $error("out-of-range measurement with nonzero distance");

  a_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !advance) |=> (in_valid_r && $stable(req_r) && $stable(cap_r)))
    else $error("pending request lost during stall");
`endif

endmodule
